### hw/rtl/pbta_pkg.sv
// Package with the types, constants and helper functions of the paged tile allocator.
package pbta_pkg;

	localparam int PAGE_COUNT     = 3;
	localparam int BYTES_PER_PAGE = 32;

	localparam int KIND_W      = 2;
	localparam int PAGE_W      = 2;
	localparam int TILE_W      = 8;
	localparam int BIT_IDX_W   = 3;
	localparam int WORD_W      = 8;
	localparam int PAGE_CMP_W  = 4;
	localparam int TBYTE_W     = TILE_W - BIT_IDX_W;
	localparam int BYTE_IDX_W  = (BYTES_PER_PAGE > 1) ? $clog2(BYTES_PER_PAGE) : 1;
	localparam int ENTRY_COUNT = PAGE_COUNT * BYTES_PER_PAGE;
	localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

	localparam logic [WORD_W-1:0] FULL_WORD     = 8'hFF;
	localparam logic [WORD_W-1:0] RESERVED_WORD = 8'h01;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIND     = 2'd0,
		KIND_ALLOC    = 2'd1,
		KIND_FREE     = 2'd2,
		KIND_FREE_ALL = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_MOD  = 1'b1
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_full;
		logic              clr_en;
		logic [PAGE_W-1:0] clr_page;
	} occ_upd_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [PAGE_W-1:0] pg,
		input logic [BYTE_IDX_W-1:0] b);
		return ADDR_W'(int'(pg) * BYTES_PER_PAGE + int'(b));
	endfunction

	function automatic logic [BIT_IDX_W-1:0] first_zero_bit(input logic [WORD_W-1:0] w);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### hw/rtl/pbta_req_if.sv
// Request channel interface carrying the operation kind, page and tile.
interface pbta_req_if import pbta_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [PAGE_W-1:0] page;
	logic [TILE_W-1:0] tile;

	modport source (output valid, output kind, output page, output tile, input ready);
	modport sink (input valid, input kind, input page, input tile, output ready);
endinterface

### hw/rtl/pbta_rsp_if.sv
// Response channel interface carrying the free tile answer of a find.
interface pbta_rsp_if import pbta_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TILE_W-1:0] free_tile;

	modport source (output valid, output free_tile, input ready);
	modport sink (input valid, input free_tile, output ready);
endinterface

### hw/rtl/pbta_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module pbta_ram #(
	parameter int DEPTH  = 96,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

### hw/rtl/pbta_occ_map.sv
// Per-byte valid and full flags with the first non-full byte search of a page.
module pbta_occ_map import pbta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PAGE_W-1:0]     lk_page,
	output logic                  lk_found,
	output logic [BYTE_IDX_W-1:0] lk_byte,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output logic                  rd_vld,
	input  occ_upd_t              upd
);
	logic [ENTRY_COUNT-1:0] vld_q;
	logic [ENTRY_COUNT-1:0] full_q;
	logic                   page_ok;

	assign page_ok = ({{(PAGE_CMP_W - PAGE_W){1'b0}}, lk_page} < PAGE_CMP_W'(PAGE_COUNT));

	always_comb begin
		lk_found = 1'b0;
		lk_byte  = '0;
		for (int j = BYTES_PER_PAGE - 1; j >= 0; j--) begin
			if (page_ok && !full_q[entry_addr(lk_page, BYTE_IDX_W'(j))]) begin
				lk_found = 1'b1;
				lk_byte  = BYTE_IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			full_q <= '0;
			rd_vld <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld <= vld_q[rd_addr];
			end
			if (upd.clr_en) begin
				for (int j = 0; j < BYTES_PER_PAGE; j++) begin
					vld_q[entry_addr(upd.clr_page, BYTE_IDX_W'(j))]  <= 1'b0;
					full_q[entry_addr(upd.clr_page, BYTE_IDX_W'(j))] <= 1'b0;
				end
			end
			if (upd.wr_en) begin
				vld_q[upd.wr_addr]  <= 1'b1;
				full_q[upd.wr_addr] <= upd.wr_full;
			end
		end
	end
endmodule

### hw/rtl/paged_bitmap_tile_allocator_top.sv
// Top level of the paged tile allocator: sequencer, bitmap memory and result register.
//
//   channel  role    payload                   transfer when
//   req      sink    kind, page, tile          req.valid && req.ready
//   rsp      source  free_tile (finds only)    rsp.valid && rsp.ready
//
// The transfer cycle issues the bitmap read (none for a free-all) and the next
// cycle modifies and writes the byte back or encodes the find answer.
// The bitmap read-modify-write takes no new item before the last one is done.
// Reset clears the valid and full flags at once, so no clearing pass is needed.
// A find whose answer meets a full, unread result register waits in ST_MOD.
module paged_bitmap_tile_allocator_top import pbta_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	pbta_req_if.sink   req,
	pbta_rsp_if.source rsp
);
	state_t                state_q, state_d;
	logic                  accept, mod_fire, slot_free;
	logic                  page_ok, tbyte_ok;
	logic                  lk_found;
	logic [BYTE_IDX_W-1:0] lk_byte;
	logic [BYTE_IDX_W-1:0] rd_byte;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  rd_en;
	logic                  rd_vld;
	logic [WORD_W-1:0]     rd_data;
	logic [WORD_W-1:0]     word, new_word, wr_data;
	logic                  wr_en;
	occ_upd_t              upd;

	kind_t                 kind_s1;
	logic [PAGE_W-1:0]     page_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [BYTE_IDX_W-1:0] byte_s1;
	logic [BIT_IDX_W-1:0]  bit_s1;
	logic                  ok_s1;
	logic                  found_s1;

	logic                  out_vld_q;
	logic [TILE_W-1:0]     free_tile_q;

	assign page_ok  = ({{(PAGE_CMP_W - PAGE_W){1'b0}}, req.page} < PAGE_CMP_W'(PAGE_COUNT));
	assign tbyte_ok = ({1'b0, req.tile[TILE_W-1:BIT_IDX_W]} < (TBYTE_W + 1)'(BYTES_PER_PAGE));
	assign rd_byte  = (kind_t'(req.kind) == KIND_FIND) ? lk_byte
		: BYTE_IDX_W'(req.tile[TILE_W-1:BIT_IDX_W]);
	assign rd_addr  = entry_addr(req.page, rd_byte);
	assign rd_en    = accept && page_ok && (kind_t'(req.kind) != KIND_FREE_ALL);

	assign slot_free = !out_vld_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (kind_s1 != KIND_FIND || slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mod_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_MOD:  mod_fire  = (kind_s1 != KIND_FIND) || slot_free;
			default: req.ready = 1'b0;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(req.kind);
			page_s1  <= req.page;
			addr_s1  <= rd_addr;
			byte_s1  <= lk_byte;
			bit_s1   <= req.tile[BIT_IDX_W-1:0];
			found_s1 <= lk_found;
			ok_s1    <= page_ok && (kind_t'(req.kind) == KIND_FIND
				|| kind_t'(req.kind) == KIND_FREE_ALL || tbyte_ok);
		end
	end

	assign word = rd_vld ? rd_data : '0;

	always_comb begin
		new_word = word;
		unique case (kind_s1)
			KIND_ALLOC: new_word = word | (WORD_W'(1) << bit_s1);
			KIND_FREE:  new_word = word & ~(WORD_W'(1) << bit_s1);
			default:    new_word = word;
		endcase
	end

	assign wr_en   = mod_fire && ok_s1 && (kind_s1 != KIND_FIND);
	assign wr_data = (kind_s1 == KIND_FREE_ALL) ? RESERVED_WORD : new_word;

	always_comb begin
		upd          = '0;
		upd.wr_en    = wr_en;
		upd.wr_addr  = (kind_s1 == KIND_FREE_ALL) ? entry_addr(page_s1, '0) : addr_s1;
		upd.wr_full  = (wr_data == FULL_WORD);
		upd.clr_en   = mod_fire && ok_s1 && (kind_s1 == KIND_FREE_ALL);
		upd.clr_page = page_s1;
	end

	pbta_ram #(
		.DEPTH (ENTRY_COUNT),
		.WIDTH (WORD_W),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(upd.wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pbta_occ_map u_occ_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.lk_page (req.page),
		.lk_found(lk_found),
		.lk_byte (lk_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_vld  (rd_vld),
		.upd     (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (mod_fire && kind_s1 == KIND_FIND) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mod_fire && kind_s1 == KIND_FIND) begin
			free_tile_q <= (ok_s1 && found_s1)
				? TILE_W'({byte_s1, first_zero_bit(word)}) : '0;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.free_tile = free_tile_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("Bitmap written while no item is in progress.");

	a_update_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind_t'(req.kind) != KIND_FIND && !rsp.valid) |=> ##1 !rsp.valid)
		else $error("An update produced a result transfer.");

	a_find_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind_t'(req.kind) == KIND_FIND && !rsp.valid) |=> ##1 rsp.valid)
		else $error("A find did not produce its result in time.");
endmodule
